// ----- rtl/core/pctl_pkg.sv -----
// ----------------------------------------------------------------------------
// pctl_pkg: shared types and constants of the pair-correlation interpolator
// Table geometry, fixed-point constants and the per-item side record that
// travels with each beat through the divider pipeline.
// ----------------------------------------------------------------------------
package pctl_pkg;

  // Table geometry
  localparam int unsigned R_POINTS   = 2048;
  localparam int unsigned ETA_STEPS  = 10;
  localparam int unsigned ROW_W      = 4;
  localparam int unsigned SAMPLE_W   = $clog2(R_POINTS);
  localparam int unsigned HALF_SW    = SAMPLE_W - 1;
  localparam int unsigned ROWADR_W   = ROW_W - 1;
  localparam int unsigned BANK_DEPTH = ((ETA_STEPS / 2) + 1) * (R_POINTS / 2);
  localparam int unsigned BANK_AW    = ROWADR_W + HALF_SW;
  localparam int unsigned NBANKS     = 4;

  // Number formats
  localparam int unsigned VAL_W   = 24;  // Q8.16
  localparam int unsigned FRAC_W  = 16;  // Q0.16
  localparam int unsigned SCALE_W = 5;
  localparam int unsigned LO_W    = SCALE_W;
  localparam int unsigned ETA_SCALE = 2 * ETA_STEPS;

  localparam logic [VAL_W-1:0]  TWO_Q16   = 24'd131072;
  localparam logic [VAL_W-1:0]  ONE_Q16   = 24'd65536;
  localparam logic [VAL_W-1:0]  FAR_LIMIT = 24'd982056;
  localparam logic [FRAC_W-1:0] STEP_RESET = 16'd655;

  // Divider geometry: numerator is (distance offset) with 16 fraction bits
  localparam int unsigned NUM_W = 21;
  localparam int unsigned DEN_W = FRAC_W + 1;
  localparam int unsigned QUO_W = NUM_W + FRAC_W;

  // Stream packing
  localparam int unsigned S_TDATA_W = 80;
  localparam int unsigned M_TDATA_W = 24;

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_QUERY = 1'b1
  } mode_e;

  typedef struct packed {
    mode_e                mode;
    logic [ROW_W-1:0]     row;
    logic [SAMPLE_W-1:0]  sample;
    logic [VAL_W-1:0]     value;
    logic                 below_two;
    logic                 beyond_rows;
    logic                 far;
    logic [LO_W-1:0]      lo;
    logic [FRAC_W-1:0]    ef;
  } side_t;

endpackage

// ----- rtl/core/pctl_div.sv -----
// ----------------------------------------------------------------------------
// pctl_div: pipelined restoring divider
// One quotient bit per stage; returns floor((num << 16) / den) and carries
// the item's side record alongside.
// ----------------------------------------------------------------------------
module pctl_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        in_vld_i,
  input  pctl_pkg::side_t             in_side_i,
  input  logic [pctl_pkg::NUM_W-1:0]  num_i,
  input  logic [pctl_pkg::DEN_W-1:0]  den_i,
  output logic                        out_vld_o,
  output pctl_pkg::side_t             out_side_o,
  output logic [pctl_pkg::QUO_W-1:0]  quo_o
);
  import pctl_pkg::*;

  logic [QUO_W-1:0] vld_q;
  side_t            side_q [QUO_W];
  logic [QUO_W-1:0] nq_q   [QUO_W];
  logic [DEN_W-1:0] rem_q  [QUO_W];
  logic [DEN_W-1:0] den_q  [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic             vld_p;
    side_t            side_p;
    logic [QUO_W-1:0] nq_p;
    logic [DEN_W-1:0] rem_p;
    logic [DEN_W-1:0] den_p;
    logic [DEN_W:0]   trial;
    logic             ge;
    logic [DEN_W-1:0] rem_n;

    if (k == 0) begin : g_first
      assign vld_p  = in_vld_i;
      assign side_p = in_side_i;
      assign nq_p   = {num_i, {FRAC_W{1'b0}}};
      assign rem_p  = '0;
      assign den_p  = den_i;
    end else begin : g_next
      assign vld_p  = vld_q[k-1];
      assign side_p = side_q[k-1];
      assign nq_p   = nq_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign den_p  = den_q[k-1];
    end

    // Shift in the next numerator bit, subtract when it fits
    assign trial = {rem_p, nq_p[QUO_W-1]};
    assign ge    = trial >= {1'b0, den_p};
    assign rem_n = ge ? DEN_W'(trial - {1'b0, den_p}) : trial[DEN_W-1:0];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (adv_i) begin
        vld_q[k] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        side_q[k] <= side_p;
        nq_q[k]   <= {nq_p[QUO_W-2:0], ge};
        rem_q[k]  <= rem_n;
        den_q[k]  <= den_p;
      end
    end
  end

  assign out_vld_o  = vld_q[QUO_W-1];
  assign out_side_o = side_q[QUO_W-1];
  assign quo_o      = nq_q[QUO_W-1];

endmodule

// ----- rtl/core/pctl_tbl.sv -----
// ----------------------------------------------------------------------------
// pctl_tbl: banked correlation table
// Four banks split by row parity and sample parity, so the four corners of
// one interpolation cell come from four different banks and are read in the same cycle.
// ----------------------------------------------------------------------------
module pctl_tbl (
  input  logic                                          clk_i,
  input  logic                                          adv_i,
  input  logic                                          we_i,
  input  logic [1:0]                                    wbank_i,
  input  logic [pctl_pkg::BANK_AW-1:0]                  waddr_i,
  input  logic [pctl_pkg::VAL_W-1:0]                    wdata_i,
  input  logic [pctl_pkg::NBANKS-1:0][pctl_pkg::BANK_AW-1:0] raddr_i,
  output logic [pctl_pkg::NBANKS-1:0][pctl_pkg::VAL_W-1:0]   rdata_o
);
  import pctl_pkg::*;

  for (genvar b = 0; b < NBANKS; b++) begin : g_bank
    logic [VAL_W-1:0] mem_q [BANK_DEPTH];
    logic [VAL_W-1:0] rdata_q;

    always_ff @(posedge clk_i) begin
      if (we_i && (wbank_i == 2'(b))) begin
        mem_q[waddr_i] <= wdata_i;
      end
      if (adv_i) begin
        rdata_q <= mem_q[raddr_i[b]];
      end
    end

    assign rdata_o[b] = rdata_q;
  end

endmodule

// ----- rtl/core/pair_correlation_table_interp.sv -----
// ----------------------------------------------------------------------------
// pair_correlation_table_interp: bilinear pair-correlation table lookup
// Holds an 11-row by 2048-sample table and answers distance/packing queries
// by interpolating in distance within two rows, then blending the rows.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake           | Payload
//  ---------+-----------+---------------------+---------------------------------
//  s_axis   | in        | tvalid/tready       | tuser: mode; tdata: row, sample,
//           |           |                     | entry value, packing, distance
//  m_axis   | out       | tvalid/tready       | tdata: result; tuser: in_range
//  cfg      | in        | cfg_we_i only       | cfg_wdata_i: radius step
//
//  One beat enters per cycle while the pipe is not held; the pipe depth is set
//  by the 37-stage bit-per-stage divider that forms the sample
//  index and the distance fraction. Load beats travel the same pipe and
//  write the table at the read stage, so queries see loads in beat order;
//  loads produce no output beat. The whole pipe holds while the output
//  register is full and not taken. Reset clears valid bits and restores the
//  radius step; the table contents stay unknown until written.
//
module pair_correlation_table_interp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // stream in
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // tdata from bit 0: row_index[4], sample_index[11], entry_value[24],
  // packing[16], distance[24], one zero pad bit
  input  logic [pctl_pkg::S_TDATA_W-1:0]     s_axis_tdata_i,
  input  logic                               s_axis_tuser_i,  // mode
  // stream out
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [pctl_pkg::M_TDATA_W-1:0]     m_axis_tdata_o,  // result_value[24]
  output logic                               m_axis_tuser_o,  // in_range
  // configuration
  input  logic                               cfg_we_i,
  input  logic [pctl_pkg::FRAC_W-1:0]        cfg_wdata_i      // radius_step
);
  import pctl_pkg::*;

  typedef struct packed {
    logic              vld;
    mode_e             mode;
    logic              below_two;
    logic              beyond_rows;
    logic              far;
    logic [FRAC_W-1:0] ef;
  } ctl_t;

  // Global advance: every stage moves when the output slot is free
  logic adv;
  logic out_vld_q;
  assign adv             = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  // Radius step register
  logic [FRAC_W-1:0] step_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_RESET;
    end else if (cfg_we_i) begin
      step_q <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------------- input
  logic                 s0_vld_q;
  logic                 s0_user_q;
  logic [S_TDATA_W-1:0] s0_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (adv) begin
      s0_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_user_q <= s_axis_tuser_i;
      s0_data_q <= s_axis_tdata_i;
    end
  end

  // ---------------------------------------------------------------- prep
  // Row pair from packing, case flags, and divider operands. Near contact
  // divides d2 by s; the middle range divides d2+s by 2s; the integer part
  // of the quotient is the sample index, the low 16 bits the fraction.
  logic [FRAC_W-1:0]          pack;
  logic [VAL_W-1:0]           sep;
  logic [FRAC_W+SCALE_W-1:0]  scaled;
  logic [FRAC_W-1:0]          step_eff;
  logic [VAL_W:0]             d2;
  logic                       near;
  logic [VAL_W:0]             d2s;
  logic [NUM_W-1:0]           div_num;
  logic [DEN_W-1:0]           div_den;
  side_t                      prep_side;

  always_comb begin
    pack     = s0_data_q[54:39];
    sep      = s0_data_q[78:55];
    scaled   = (FRAC_W+SCALE_W)'(pack) * (FRAC_W+SCALE_W)'(ETA_SCALE);
    step_eff = (step_q == '0) ? FRAC_W'(1) : step_q;
    d2       = {sep - TWO_Q16, 1'b0};
    near     = d2 < (VAL_W+1)'(step_eff);
    d2s      = d2 + (VAL_W+1)'(step_eff);
    div_num  = near ? d2[NUM_W-1:0] : d2s[NUM_W-1:0];
    div_den  = near ? {1'b0, step_eff} : {step_eff, 1'b0};

    prep_side.mode        = mode_e'(s0_user_q);
    prep_side.row         = s0_data_q[3:0];
    prep_side.sample      = s0_data_q[14:4];
    prep_side.value       = s0_data_q[38:15];
    prep_side.below_two   = sep < TWO_Q16;
    prep_side.lo          = scaled[FRAC_W+SCALE_W-1:FRAC_W];
    prep_side.beyond_rows = scaled[FRAC_W+SCALE_W-1:FRAC_W] >= LO_W'(ETA_STEPS);
    prep_side.far         = sep > FAR_LIMIT;
    prep_side.ef          = scaled[FRAC_W-1:0];
  end

  // ---------------------------------------------------------------- divide
  logic             dv_vld;
  side_t            dv_side;
  logic [QUO_W-1:0] dv_quo;

  pctl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .in_vld_i   (s0_vld_q),
    .in_side_i  (prep_side),
    .num_i      (div_num),
    .den_i      (div_den),
    .out_vld_o  (dv_vld),
    .out_side_o (dv_side),
    .quo_o      (dv_quo)
  );

  // ---------------------------------------------------------------- table
  // Clamp both sample indices at the last entry, then steer each index to
  // the bank of its parity. Even-row banks hold the upper row when lo is
  // odd, so their row address is (lo+1)/2; odd-row banks take lo/2.
  localparam logic [SAMPLE_W-1:0] LAST_SAMPLE = SAMPLE_W'(R_POINTS - 1);

  logic [NUM_W-1:0]                    j_full;
  logic [SAMPLE_W-1:0]                 jc;
  logic [SAMPLE_W-1:0]                 jn;
  logic [LO_W-1:0]                     lo_p1;
  logic [NBANKS-1:0][BANK_AW-1:0]      raddr;
  logic [NBANKS-1:0][VAL_W-1:0]        rdata;
  logic                                tbl_we;
  logic [1:0]                          tbl_wbank;
  logic [BANK_AW-1:0]                  tbl_waddr;

  always_comb begin
    j_full = dv_quo[QUO_W-1:FRAC_W];
    jc     = (j_full > NUM_W'(LAST_SAMPLE)) ? LAST_SAMPLE : j_full[SAMPLE_W-1:0];
    jn     = (jc == LAST_SAMPLE) ? LAST_SAMPLE : jc + SAMPLE_W'(1);
    lo_p1  = dv_side.lo + LO_W'(1);
    for (int b = 0; b < NBANKS; b++) begin
      raddr[b][BANK_AW-1:HALF_SW] = b[1] ? dv_side.lo[ROWADR_W:1] : lo_p1[ROWADR_W:1];
      if (b[0] == jc[0]) begin
        raddr[b][HALF_SW-1:0] = jc[SAMPLE_W-1:1];
      end else begin
        raddr[b][HALF_SW-1:0] = jn[SAMPLE_W-1:1];
      end
    end

    tbl_we    = adv && dv_vld && (dv_side.mode == MODE_LOAD)
                && (dv_side.row <= ROW_W'(ETA_STEPS));
    tbl_wbank = {dv_side.row[0], dv_side.sample[0]};
    tbl_waddr = {dv_side.row[ROW_W-1:1], dv_side.sample[SAMPLE_W-1:1]};
  end

  pctl_tbl u_tbl (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .we_i    (tbl_we),
    .wbank_i (tbl_wbank),
    .waddr_i (tbl_waddr),
    .wdata_i (dv_side.value),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Side data aligned with the registered read
  ctl_t              m_ctl_q;
  logic [FRAC_W-1:0] m_f_q;
  logic              m_lo0_q;
  logic              m_jc0_q;
  logic              m_jn0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ctl_q <= '0;
    end else if (adv) begin
      m_ctl_q.vld         <= dv_vld;
      m_ctl_q.mode        <= dv_side.mode;
      m_ctl_q.below_two   <= dv_side.below_two;
      m_ctl_q.beyond_rows <= dv_side.beyond_rows;
      m_ctl_q.far         <= dv_side.far;
      m_ctl_q.ef          <= dv_side.ef;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_f_q   <= dv_quo[FRAC_W-1:0];
      m_lo0_q <= dv_side.lo[0];
      m_jc0_q <= jc[0];
      m_jn0_q <= jn[0];
    end
  end

  // ---------------------------------------------------------------- row blend
  // a + ((b - a) * f) >>> 16 equals (a*(1-f) + b*f) >> 16 with floor.
  localparam int unsigned PROD_W = (VAL_W + 1) + (FRAC_W + 1);
  localparam int unsigned SUM_W  = PROD_W - FRAC_W;

  logic [VAL_W-1:0]         a_lo, b_lo, a_hi, b_hi;
  logic signed [VAL_W:0]    dif_lo, dif_hi;
  logic signed [PROD_W-1:0] prod_lo, prod_hi;

  always_comb begin
    a_lo    = rdata[{m_lo0_q, m_jc0_q}];
    b_lo    = rdata[{m_lo0_q, m_jn0_q}];
    a_hi    = rdata[{!m_lo0_q, m_jc0_q}];
    b_hi    = rdata[{!m_lo0_q, m_jn0_q}];
    dif_lo  = $signed({1'b0, b_lo}) - $signed({1'b0, a_lo});
    dif_hi  = $signed({1'b0, b_hi}) - $signed({1'b0, a_hi});
    prod_lo = PROD_W'(dif_lo) * $signed({1'b0, m_f_q});
    prod_hi = PROD_W'(dif_hi) * $signed({1'b0, m_f_q});
  end

  ctl_t                     p1_ctl_q;
  logic [VAL_W-1:0]         p1_alo_q, p1_ahi_q;
  logic signed [PROD_W-1:0] p1_plo_q, p1_phi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_ctl_q <= '0;
    end else if (adv) begin
      p1_ctl_q <= m_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_alo_q <= a_lo;
      p1_ahi_q <= a_hi;
      p1_plo_q <= prod_lo;
      p1_phi_q <= prod_hi;
    end
  end

  logic signed [SUM_W-1:0] sum_lo, sum_hi;
  assign sum_lo = $signed(SUM_W'(p1_alo_q)) + SUM_W'(p1_plo_q >>> FRAC_W);
  assign sum_hi = $signed(SUM_W'(p1_ahi_q)) + SUM_W'(p1_phi_q >>> FRAC_W);

  ctl_t             p2_ctl_q;
  logic [VAL_W-1:0] p2_vlo_q, p2_vhi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_ctl_q <= '0;
    end else if (adv) begin
      p2_ctl_q <= p1_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p2_vlo_q <= sum_lo[VAL_W-1:0];
      p2_vhi_q <= sum_hi[VAL_W-1:0];
    end
  end

  // ---------------------------------------------------------------- eta blend
  logic signed [VAL_W:0]    dif_eta;
  logic signed [PROD_W-1:0] prod_eta;
  assign dif_eta  = $signed({1'b0, p2_vhi_q}) - $signed({1'b0, p2_vlo_q});
  assign prod_eta = PROD_W'(dif_eta) * $signed({1'b0, p2_ctl_q.ef});

  ctl_t                     p3_ctl_q;
  logic [VAL_W-1:0]         p3_vlo_q;
  logic signed [PROD_W-1:0] p3_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_ctl_q <= '0;
    end else if (adv) begin
      p3_ctl_q <= p2_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p3_vlo_q  <= p2_vlo_q;
      p3_prod_q <= prod_eta;
    end
  end

  // ---------------------------------------------------------------- output
  // Blends stay between their end points, so the result never needs clipping.
  logic signed [SUM_W-1:0] sum_eta;
  logic [VAL_W-1:0]        res_d;
  logic                    in_range_d;

  always_comb begin
    sum_eta    = $signed(SUM_W'(p3_vlo_q)) + SUM_W'(p3_prod_q >>> FRAC_W);
    res_d      = sum_eta[VAL_W-1:0];
    in_range_d = 1'b1;
    if (p3_ctl_q.below_two) begin
      res_d = '0;
    end else if (p3_ctl_q.beyond_rows) begin
      res_d      = '0;
      in_range_d = 1'b0;
    end else if (p3_ctl_q.far) begin
      res_d = ONE_Q16;
    end
  end

  logic [VAL_W-1:0] out_data_q;
  logic             out_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= p3_ctl_q.vld && (p3_ctl_q.mode == MODE_QUERY);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= res_d;
      out_user_q <= in_range_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  // ---------------------------------------------------------------- checks
  a_nan_is_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tdata_o == '0))
    else $error("out-of-range result carries a nonzero value");

  a_ready_tracks_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("input ready does not follow output slot");

  a_write_on_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_we |-> (dv_vld && adv && (dv_side.mode == MODE_LOAD)))
    else $error("table written by a non-load beat");

  a_out_from_query : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(p3_ctl_q.vld && (p3_ctl_q.mode == MODE_QUERY)))
    else $error("output beat without a query behind it");

endmodule
